// ----- hdl/lae_pkg.sv -----
// ----------------------------------------------------------------------------
// lae_pkg
// Types, constants and register map shared by the lateral acceleration
// estimator modules.
// ----------------------------------------------------------------------------
package lae_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned ALPHA_W = 17;
	localparam int unsigned MIN_RADIUS_W = 16;
	localparam int unsigned ALPHA_BITS = 16;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned PADDR_W = 3;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
	localparam logic [MIN_RADIUS_W-1:0] MIN_RADIUS_RESET = 16'd1;

	// Input opcodes.
	localparam logic OPC_VELOCITY = 1'b0;
	localparam logic OPC_RADIUS = 1'b1;

	// Register index, taken from paddr[2].
	typedef enum logic {
		REG_ALPHA = 1'b0,
		REG_MIN_RADIUS = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_VELOCITY = 1'b0,
		KIND_RADIUS = 1'b1
	} kind_t;

	typedef struct packed {
		logic opcode;
		logic signed [WORD_BITS-1:0] sample_value;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] lateral_accel;
		logic saturated;
	} out_word_t;

	// Classified command waiting in the queue.
	typedef struct packed {
		kind_t kind;
		logic signed [WORD_BITS-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [MIN_RADIUS_W-1:0] min_radius;
	} cfg_t;

endpackage

// ----- hdl/lae_front.sv -----
// ----------------------------------------------------------------------------
// lae_front
// Accepts input words, classifies them by opcode and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module lae_front #(
	parameter int unsigned QUEUE_DEPTH = lae_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lae_pkg::in_word_t in_data,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output lae_pkg::cmd_t     cmd
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	lae_pkg::cmd_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;
	lae_pkg::cmd_t cmd_in;

	assign in_stall = (count_q == CNT_FULL);
	assign push = in_valid && !in_stall;
	assign pop = cmd_pop && cmd_valid;
	assign cmd_valid = (count_q != '0);
	assign cmd = entry_q[rd_ptr_q];

	always_comb begin
		cmd_in.kind = (in_data.opcode == lae_pkg::OPC_RADIUS) ?
			lae_pkg::KIND_RADIUS : lae_pkg::KIND_VELOCITY;
		cmd_in.value = in_data.sample_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/lae_back.sv -----
// ----------------------------------------------------------------------------
// lae_back
// Carries out one command at a time: velocity filter update or radius load,
// then squaring, a bit-serial division and saturation into the output
// register.
// ----------------------------------------------------------------------------
module lae_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lae_pkg::cfg_t      cfg,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  lae_pkg::cmd_t      cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output lae_pkg::out_word_t out_data
);

	localparam int unsigned W = lae_pkg::WORD_BITS;
	localparam int unsigned QUO_W = W + 1;
	localparam int unsigned PROD_W = (W + 1) + (lae_pkg::ALPHA_W + 1);
	localparam int unsigned DIV_STEPS = QUO_W;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
	localparam logic [QUO_W-1:0] POS_LIMIT = {2'b00, {(W-1){1'b1}}};
	localparam logic [QUO_W-1:0] NEG_LIMIT = {2'b01, {(W-1){1'b0}}};
	localparam logic [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_FILT   = 6'b000010,
		ST_SQUARE = 6'b000100,
		ST_DIVSET = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	state_t state_q;
	logic signed [W-1:0] vel_q;
	logic first_q;
	logic signed [W-1:0] rad_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [2*W-1:0] sq_q;
	logic [W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic ovf_q;
	logic out_valid_q;
	lae_pkg::out_word_t out_q;

	logic [lae_pkg::ALPHA_W-1:0] alpha_sat;
	logic signed [W:0] diff;
	logic signed [PROD_W-1:0] step_w;
	logic [W-1:0] vmag;
	logic [W-1:0] rmag;
	logic no_result;
	logic [W-2:0] sq_hi;
	logic [W:0] trial;
	logic trial_ge;
	logic out_free;
	lae_pkg::out_word_t res;

	assign alpha_sat = (cfg.alpha > lae_pkg::ALPHA_ONE) ? lae_pkg::ALPHA_ONE : cfg.alpha;
	assign diff = {cmd.value[W-1], cmd.value} - {vel_q[W-1], vel_q};
	// Arithmetic shift of the signed product rounds toward minus infinity.
	assign step_w = prod_q >>> lae_pkg::ALPHA_BITS;
	assign vmag = vel_q[W-1] ? W'(-vel_q) : vel_q;
	assign rmag = rad_q[W-1] ? W'(-rad_q) : rad_q;
	assign no_result = (rmag == '0) || (rmag < W'(cfg.min_radius));
	assign sq_hi = sq_q[2*W-1:QUO_W];
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign trial_ge = (trial >= {1'b0, rmag});
	assign out_free = !out_valid_q || !out_stall;
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		res.saturated = 1'b0;
		res.lateral_accel = '0;
		if (!rad_q[W-1]) begin
			if (ovf_q || (quo_q > POS_LIMIT)) begin
				res.saturated = 1'b1;
				res.lateral_accel = S_MAX;
			end else begin
				res.lateral_accel = quo_q[W-1:0];
			end
		end else begin
			if (ovf_q || (quo_q > NEG_LIMIT)) begin
				res.saturated = 1'b1;
				res.lateral_accel = S_MIN;
			end else begin
				res.lateral_accel = W'(-quo_q[W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				prod_q <= diff * $signed({1'b0, alpha_sat});
			end
			ST_SQUARE: begin
				sq_q <= (2*W)'(vmag) * (2*W)'(vmag);
			end
			ST_DIVSET: begin
				rem_q <= {1'b0, sq_hi};
				quo_q <= sq_q[QUO_W-1:0];
			end
			ST_DIV: begin
				rem_q <= trial_ge ? W'(trial - {1'b0, rmag}) : trial[W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], trial_ge};
			end
			ST_FILT, ST_OUT: begin
			end
			default: begin
			end
		endcase
		if ((state_q == ST_OUT) && out_free) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vel_q <= '0;
			first_q <= 1'b1;
			rad_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.kind == lae_pkg::KIND_RADIUS) begin
							rad_q <= cmd.value;
							state_q <= ST_SQUARE;
						end else if (first_q) begin
							// The first velocity word seeds the filter.
							vel_q <= cmd.value;
							first_q <= 1'b0;
							state_q <= ST_SQUARE;
						end else begin
							state_q <= ST_FILT;
						end
					end
				end
				ST_FILT: begin
					vel_q <= vel_q + step_w[W-1:0];
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					state_q <= no_result ? ST_IDLE : ST_DIVSET;
				end
				ST_DIVSET: begin
					cnt_q <= '0;
					// A high part not below the divisor means the quotient
					// is far beyond the 32-bit range.
					if ({1'b0, sq_hi} >= rmag) begin
						ovf_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						ovf_q <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/lateral_accel_estimator.sv -----
// ----------------------------------------------------------------------------
// lateral_accel_estimator
// Filters velocity words, keeps the turning radius and outputs v*v/r in
// Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Each input word is a velocity or a radius; after either, one result word
// v*v/r follows unless the radius magnitude is zero or below min_radius.
// The front queue takes new words while the back end works. The back end
// handles one word at a time: filter update or radius load, squaring,
// the 33-step bit-serial divider and the output register. It skips the
// divider when no result is due or when the quotient overflows early.
// A result waiting in the output register does not hold the front end.
module lateral_accel_estimator #(
	parameter int unsigned QUEUE_DEPTH = lae_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lae_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lae_pkg::in_word_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lae_pkg::out_word_t          out_data
);

	lae_pkg::cfg_t cfg_q;
	lae_pkg::reg_idx_t reg_idx;
	logic wr_en;
	logic cmd_valid;
	logic cmd_pop;
	lae_pkg::cmd_t cmd;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = lae_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_idx)
			lae_pkg::REG_ALPHA: prdata = 32'(cfg_q.alpha);
			lae_pkg::REG_MIN_RADIUS: prdata = 32'(cfg_q.min_radius);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha <= lae_pkg::ALPHA_RESET;
			cfg_q.min_radius <= lae_pkg::MIN_RADIUS_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				lae_pkg::REG_ALPHA: cfg_q.alpha <= pwdata[lae_pkg::ALPHA_W-1:0];
				lae_pkg::REG_MIN_RADIUS: cfg_q.min_radius <= pwdata[lae_pkg::MIN_RADIUS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lae_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd)
	);

	lae_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ----- tb/lae_checker.sv -----
// ----------------------------------------------------------------------------
// lae_checker
// Watches the register port and both word channels of the lateral
// acceleration estimator. It keeps its own filter, radius and register state,
// predicts each result word when an input word is taken, and compares the
// result words in order, field by field.
// ----------------------------------------------------------------------------
module lae_checker
	import lae_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_word_t            in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_word_t           out_data,
	output int                  errors,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 100;

	logic [ALPHA_W-1:0] alpha_reg;
	logic [MIN_RADIUS_W-1:0] min_radius_reg;
	logic signed [WORD_BITS-1:0] velocity_avg;
	logic signed [WORD_BITS-1:0] radius;
	bit seeding;
	out_word_t accel_expected[$];

	initial begin
		errors = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP)
			$display("%0t ns checker: %s", $realtime, msg);
		errors++;
	endtask

	// Applies one input word to the local state and works out the result
	// word, if the radius allows one.
	function automatic bit predict_accel(input in_word_t w, output out_word_t res);
		logic [ALPHA_W-1:0] a;
		longint diff;
		longint step;
		longint r;
		longint v;
		logic [63:0] rmag;
		logic [63:0] vmag;
		logic [63:0] quo;
		res = '0;
		if (w.opcode == OPC_VELOCITY) begin
			if (seeding) begin
				velocity_avg = w.sample_value;
				seeding = 1'b0;
			end else begin
				a = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
				diff = longint'($signed(w.sample_value)) - longint'($signed(velocity_avg));
				// Arithmetic shift of the signed product rounds toward minus infinity.
				step = (diff * longint'(a)) >>> ALPHA_BITS;
				velocity_avg = velocity_avg + step[31:0];
			end
		end else begin
			radius = w.sample_value;
		end

		r = longint'($signed(radius));
		rmag = (r < 0) ? -r : r;
		if (rmag == 0 || rmag < min_radius_reg)
			return 1'b0;
		v = longint'($signed(velocity_avg));
		vmag = (v < 0) ? -v : v;
		quo = (vmag * vmag) / rmag;
		if (r > 0) begin
			if (quo > 64'd2147483647) begin
				quo = 64'd2147483647;
				res.saturated = 1'b1;
			end
			res.lateral_accel = quo[31:0];
		end else begin
			// The most negative value itself is reachable without clipping.
			if (quo > 64'd2147483648) begin
				quo = 64'd2147483648;
				res.saturated = 1'b1;
			end
			res.lateral_accel = -quo[31:0];
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t head;
		out_word_t predicted;
		if (!arst_n) begin
			alpha_reg = ALPHA_RESET;
			min_radius_reg = MIN_RADIUS_RESET;
			velocity_avg = '0;
			radius = '0;
			seeding = 1'b1;
			accel_expected.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_ALPHA: alpha_reg = pwdata[ALPHA_W-1:0];
					REG_MIN_RADIUS: min_radius_reg = pwdata[MIN_RADIUS_W-1:0];
				endcase
			end
			// A result word can never stem from an input word taken at the same
			// edge, so the output side is handled first.
			if (out_valid && !out_stall) begin
				if (accel_expected.size() == 0) begin
					report_mismatch($sformatf("result word %h with none expected", out_data));
				end else begin
					head = accel_expected.pop_front();
					if (out_data.lateral_accel !== head.lateral_accel)
						report_mismatch($sformatf("lateral_accel %h, expected %h",
							out_data.lateral_accel, head.lateral_accel));
					if (out_data.saturated !== head.saturated)
						report_mismatch($sformatf("saturated %b, expected %b",
							out_data.saturated, head.saturated));
				end
			end
			if (in_valid && !in_stall) begin
				if (predict_accel(in_data, predicted))
					accel_expected.push_back(predicted);
			end
		end
		outstanding = accel_expected.size();
	end

endmodule

// ----- tb/lateral_accel_estimator_tb.sv -----
// ----------------------------------------------------------------------------
// lateral_accel_estimator_tb
// Drives velocity and radius words into the estimator under several register
// settings, with random bursts on the input and random stalls on the output.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module lateral_accel_estimator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lae_pkg::*;

	localparam int N_PHASES = 10;
	localparam int PHASE_WORDS = 170;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;

	int errors;
	int outstanding;
	int idle_cycles = 0;
	int burst_left = 0;
	int fill_left = 0;
	bit hold_req = 1'b0;
	logic [MIN_RADIUS_W-1:0] cur_min_radius = MIN_RADIUS_RESET;

	lateral_accel_estimator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	lae_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.errors(errors),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Output side: stall modes change at random; a hold request from the
	// stimulus keeps the output stalled long enough for the block to fill up.
	initial begin
		stall_mode_t mode;
		int left;
		int tick;
		out_stall = 1'b0;
		mode = STALL_NONE;
		left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(10, 200);
			end
			left--;
			tick++;
			case (mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
				STALL_PERIODIC: out_stall <= ((tick % 5) < 2);
				default: out_stall <= ($urandom_range(0, 99) < 80);
			endcase
		end
	end

	task automatic idle_input(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic push_word(input logic op, input logic [31:0] val);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{opcode: op, sample_value: val};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Registers change only once the block has drained; words that give no
	// result may still be in flight, hence the extra wait.
	task automatic configure(input logic [ALPHA_W-1:0] a, input logic [MIN_RADIUS_W-1:0] m);
		idle_input(1);
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_ALPHA, {{(32 - ALPHA_W){1'b0}}, a});
		write_reg(REG_MIN_RADIUS, {{(32 - MIN_RADIUS_W){1'b0}}, m});
		cur_min_radius = m;
	endtask

	task automatic pace();
		int g;
		if (fill_left > 0)
			return;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			g = $urandom_range(0, 9);
			if (g >= 8)
				idle_input($urandom_range(10, 45));
			else if (g >= 3)
				idle_input($urandom_range(1, 6));
		end
		burst_left--;
	endtask

	function automatic logic [31:0] pick_velocity();
		logic [31:0] mag;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return $urandom();
		if (sel < 8) begin
			mag = $urandom_range(0, 32'h0040_0000);
			return $urandom_range(0, 1) ? -mag : mag;
		end
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_radius();
		logic [31:0] mag;
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1: return $urandom();
			2, 3: mag = $urandom_range(1, 32'h0004_0000);
			// Straddle the minimum radius so both sides of the cut are hit.
			4: mag = cur_min_radius + $urandom_range(0, 4) - 2;
			5: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFF;
					3: return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
			default: mag = $urandom_range(32'h0000_8000, 32'h0100_0000);
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	initial begin
		int ph;
		int n;
		logic op;
		logic [ALPHA_W-1:0] a;
		logic [MIN_RADIUS_W-1:0] m;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings. The first velocity seeds the filter at 1.0 while
		// the radius is still zero, so no result word follows it.
		push_word(OPC_VELOCITY, 32'h0001_0000);
		push_word(OPC_RADIUS, 32'hFFFF_FFFE);   // exactly the most negative value
		push_word(OPC_RADIUS, 32'h0000_0002);   // just above the positive limit
		push_word(OPC_RADIUS, 32'hFFFF_FFFF);   // negative overflow
		push_word(OPC_RADIUS, 32'h7FFF_FFFF);
		push_word(OPC_RADIUS, 32'h8000_0000);
		push_word(OPC_RADIUS, 32'h0000_0000);
		push_word(OPC_RADIUS, 32'h0000_0001);
		push_word(OPC_VELOCITY, 32'h7FFF_FFFF);
		push_word(OPC_VELOCITY, 32'h8000_0000);
		push_word(OPC_VELOCITY, 32'h0000_0000);
		push_word(OPC_VELOCITY, 32'hFFFF_FFFF);
		push_word(OPC_VELOCITY, 32'h0000_0001);
		push_word(OPC_RADIUS, 32'h0001_0000);

		// Alpha above one acts as one; a zero radius stays silent with no minimum.
		configure(17'h1_FFFF, 16'h0000);
		push_word(OPC_RADIUS, 32'h0000_0000);
		push_word(OPC_RADIUS, 32'h0000_0001);
		push_word(OPC_VELOCITY, 32'h8000_0000);
		push_word(OPC_VELOCITY, 32'h7FFF_FFFF);

		// Largest minimum radius with a frozen filter.
		configure(17'h0_0000, 16'hFFFF);
		push_word(OPC_RADIUS, 32'h0000_FFFE);
		push_word(OPC_RADIUS, 32'hFFFF_0002);
		push_word(OPC_RADIUS, 32'h0000_FFFF);
		push_word(OPC_RADIUS, 32'hFFFF_0001);
		push_word(OPC_VELOCITY, 32'h0000_3039);

		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: configure(17'h0_0000, 16'h0000);
				1: configure(ALPHA_ONE, 16'hFFFF);
				2: configure(17'h1_FFFF, 16'h0001);
				3: configure(ALPHA_RESET, MIN_RADIUS_RESET);
				default: begin
					a = ALPHA_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(65537, 131071) : $urandom_range(0, 65536));
					m = MIN_RADIUS_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 65535) : $urandom_range(0, 64));
					configure(a, m);
				end
			endcase
			for (n = 0; n < PHASE_WORDS; n++) begin
				if (n == PHASE_WORDS / 2) begin
					idle_input(1);
					wait (outstanding == 0);
				end
				// Set a usable radius, then keep offering velocity words while
				// the output side is held off.
				if (ph == 2 && n == 40) begin
					push_word(OPC_RADIUS, 32'd6553600);
					hold_req = 1'b1;
					fill_left = 24;
				end
				pace();
				if (fill_left > 0) begin
					fill_left--;
					op = OPC_VELOCITY;
				end else begin
					op = ($urandom_range(0, 9) < 7) ? OPC_VELOCITY : OPC_RADIUS;
				end
				push_word(op, (op == OPC_VELOCITY) ? pick_velocity() : pick_radius());
			end
		end

		idle_input(1);
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
